>>> sv/ccc_pkg.sv
// Shared types and constants for the circular cross-correlator.
package ccc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int LAG_W    = 6;
  localparam int CORR_W   = 38;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic             load;
    logic [LAG_W-1:0] lag;
    logic             run_end;
    logic             overflowed;
  } emit_t;

endpackage

>>> sv/ccc_if.sv
// Handshake interfaces for sample pairs and correlation results.
interface ccc_sample_if
  import ccc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic                       final_pair;

  modport source (output valid, output sample_a, output sample_b, output final_pair,
                  input ready);
  modport sink   (input valid, input sample_a, input sample_b, input final_pair,
                  output ready);
endinterface

interface ccc_result_if
  import ccc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [LAG_W-1:0]  lag;
  logic signed [CORR_W-1:0] correlation;
  logic                     run_end;
  logic                     overflowed;

  modport source (output valid, output lag, output correlation, output run_end,
                  output overflowed, input ready);
  modport sink   (input valid, input lag, input correlation, input run_end,
                  input overflowed, output ready);
endinterface

>>> sv/ccc_store.sv
// Sample memories for both sequences, with fill-count zero padding on read.
module ccc_store
  import ccc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_a,
  input  logic signed [SAMPLE_W-1:0] wr_b,
  input  logic [AW-1:0]              rd_addr_a,
  input  logic [AW-1:0]              rd_addr_b,
  input  logic [CW-1:0]              count,
  output logic signed [SAMPLE_W-1:0] rd_a,
  output logic signed [SAMPLE_W-1:0] rd_b
);

  logic signed [SAMPLE_W-1:0] mem_a [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_b [DEPTH];
  logic signed [SAMPLE_W-1:0] q_a;
  logic signed [SAMPLE_W-1:0] q_b;
  logic                       keep_a;
  logic                       keep_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    q_a    <= mem_a[rd_addr_a];
    q_b    <= mem_b[rd_addr_b];
    keep_a <= CW'(rd_addr_a) < count;
    keep_b <= CW'(rd_addr_b) < count;
  end

  assign rd_a = keep_a ? q_a : '0;
  assign rd_b = keep_b ? q_b : '0;

endmodule

>>> sv/ccc_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulator.
module ccc_mac
  import ccc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  output logic signed [CORR_W-1:0]   sum,
  output logic                       done
);

  mac_ctl_t                 ctl_d1;
  mac_ctl_t                 ctl_d2;
  logic signed [PROD_W-1:0] prod;
  logic signed [CORR_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d1 <= '0;
      ctl_d2 <= '0;
      done   <= 1'b0;
    end else begin
      ctl_d1 <= ctl;
      ctl_d2 <= ctl_d1;
      done   <= ctl_d2.valid && ctl_d2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_d1.valid) begin
      prod <= a * b;
    end
    if (ctl_d2.valid) begin
      acc <= ctl_d2.first ? CORR_W'(prod) : acc + CORR_W'(prod);
    end
  end

  assign sum = acc;

endmodule

>>> sv/ccc_ctrl.sv
// Sequencer: loads pairs, walks lags and taps, hands results to the output stage.
module ccc_ctrl
  import ccc_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MIN_POINTS = 8,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_final,
  output logic          in_ready,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr_a,
  output logic [AW-1:0] rd_addr_b,
  output logic [CW-1:0] count,
  output mac_ctl_t      ctl,
  input  logic          mac_done,
  input  logic          out_free,
  output emit_t         emit
);

  localparam int DW = ((CW + 1) > LAG_W) ? (CW + 1) : LAG_W;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic          dropped;
  logic [CW-1:0] n;
  logic [CW-1:0] half;
  logic [AW-1:0] m;
  logic [AW-1:0] j;
  logic [AW-1:0] ia;
  logic [AW-1:0] shift;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] shift_inc;
  logic [CW-1:0] count_next;
  logic [CW-1:0] n_new;
  logic [CW-1:0] half_new;
  logic          accept;
  logic          store_ok;
  logic signed [DW-1:0] lag_wide;

  function automatic logic [CW-1:0] run_size(input logic [CW-1:0] cnt);
    int unsigned nn;
    nn = 1;
    for (int i = 0; i < CW; i++) begin
      if ((nn < cnt || nn < MIN_POINTS) && nn < MAX_POINTS) begin
        nn = nn << 1;
      end
    end
    if (nn > MAX_POINTS) begin
      nn = MAX_POINTS;
    end
    return CW'(nn);
  endfunction

  assign accept     = (state == ST_LOAD) && in_valid;
  assign store_ok   = count < CW'(MAX_POINTS);
  assign count_next = store_ok ? count + CW'(1) : count;
  assign n_new      = run_size(count_next);
  assign half_new   = n_new >> 1;
  assign last_idx   = AW'(n - CW'(1));
  assign shift_inc  = (shift == last_idx) ? '0 : shift + AW'(1);
  assign lag_wide   = DW'(m) - DW'(half);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && in_final) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (j == last_idx) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (mac_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = (m == last_idx) ? ST_LOAD : ST_ISSUE;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    wr_en           = 1'b0;
    ctl             = '0;
    emit            = '0;
    emit.lag        = lag_wide[LAG_W-1:0];
    emit.run_end    = (m == last_idx);
    emit.overflowed = dropped;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        wr_en    = accept && store_ok;
      end
      ST_ISSUE: begin
        ctl.valid = 1'b1;
        ctl.first = (j == '0);
        ctl.last  = (j == last_idx);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        emit.load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign wr_addr   = count[AW-1:0];
  assign rd_addr_a = ia;
  assign rd_addr_b = j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
        if (!store_ok) dropped <= 1'b1;
      end
      if (state == ST_EMIT && out_free && m == last_idx) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        if (accept && in_final) begin
          n     <= n_new;
          half  <= half_new;
          m     <= '0;
          j     <= '0;
          shift <= AW'(n_new - half_new);
          ia    <= AW'(n_new - half_new);
        end
      end
      ST_ISSUE: begin
        j  <= (j == last_idx) ? '0 : j + AW'(1);
        ia <= (ia == last_idx) ? '0 : ia + AW'(1);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (out_free && m != last_idx) begin
          m     <= m + AW'(1);
          shift <= shift_inc;
          ia    <= shift_inc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/circular_cross_correlator_unit.sv
// After the final pair each lag is worked out in turn: N taps issue through the one multiplier,
// the product and accumulator pipeline drains, then the result is handed to the output stage;
// the input is held off until the last lag of the run has been handed on.
// Throughput: one pair per cycle while loading; one lag at a time while running.
// Reset (rst, synchronous): empties the stores, clears the drop flag and the result stage.
// Top level of the circular cross-correlator.
module circular_cross_correlator_unit
  import ccc_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MIN_POINTS = 8
) (
  input logic         clk,
  input logic         rst,
  ccc_sample_if.sink  samples,
  ccc_result_if.source results
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr_a;
  logic [AW-1:0]              rd_addr_b;
  logic [CW-1:0]              count;
  logic signed [SAMPLE_W-1:0] rd_a;
  logic signed [SAMPLE_W-1:0] rd_b;
  mac_ctl_t                   ctl;
  logic signed [CORR_W-1:0]   sum;
  logic                       mac_done;
  logic                       out_free;
  emit_t                      emit;
  logic                       res_valid;
  logic signed [LAG_W-1:0]    res_lag;
  logic signed [CORR_W-1:0]   res_corr;
  logic                       res_end;
  logic                       res_ovf;

  ccc_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .MIN_POINTS(MIN_POINTS),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(samples.valid),
    .in_final(samples.final_pair),
    .in_ready(samples.ready),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .count(count),
    .ctl(ctl),
    .mac_done(mac_done),
    .out_free(out_free),
    .emit(emit)
  );

  ccc_store #(
    .DEPTH(MAX_POINTS),
    .AW(AW),
    .CW(CW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_a(samples.sample_a),
    .wr_b(samples.sample_b),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .count(count),
    .rd_a(rd_a),
    .rd_b(rd_b)
  );

  ccc_mac u_mac (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .a(rd_a),
    .b(rd_b),
    .sum(sum),
    .done(mac_done)
  );

  assign out_free = !res_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit.load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      res_lag  <= emit.lag;
      res_corr <= sum;
      res_end  <= emit.run_end;
      res_ovf  <= emit.overflowed;
    end
  end

  assign results.valid       = res_valid;
  assign results.lag         = res_lag;
  assign results.correlation = res_corr;
  assign results.run_end     = res_end;
  assign results.overflowed  = res_ovf;

endmodule

>>> sv/ccc_checker.sv
// Port-level checks for the circular cross-correlator, bound to the top level.
module ccc_checker
  import ccc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_final,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [LAG_W-1:0]  out_lag,
  input logic signed [CORR_W-1:0] out_corr,
  input logic                     out_run_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_corr) && $stable(out_lag))
    else $error("result item changed while stalled");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("input still open after final pair");

  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_run_end |-> !in_ready)
    else $error("input open in the middle of a run");

  a_end_lag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_run_end |-> !out_lag[LAG_W-1])
    else $error("last lag of a run is negative");

endmodule

bind circular_cross_correlator_unit ccc_checker u_ccc_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(samples.valid),
  .in_ready(samples.ready),
  .in_final(samples.final_pair),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_lag(results.lag),
  .out_corr(results.correlation),
  .out_run_end(results.run_end)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the circular cross-correlator: loads sample runs, predicts every lag.
module tb_top;
  import ccc_pkg::*;

  localparam int MAX_PAIRS   = 64;
  localparam int MIN_PAIRS   = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 700;
  localparam int TAIL_CYCLES = 80;

  typedef struct {
    logic signed [LAG_W-1:0]  lag;
    logic signed [CORR_W-1:0] corr;
    logic                     run_end;
    logic                     ovf;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccc_sample_if sample_ch ();
  ccc_result_if result_ch ();

  circular_cross_correlator_unit #(
    .MAX_POINTS(MAX_PAIRS),
    .MIN_POINTS(MIN_PAIRS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch),
    .results(result_ch)
  );

  always #6 clk = ~clk;

  logic signed [SAMPLE_W-1:0] seq_a [MAX_PAIRS];
  logic signed [SAMPLE_W-1:0] seq_b [MAX_PAIRS];
  int                         pair_count = 0;
  logic                       drop_seen  = 1'b0;
  corr_result_t               pending [$];
  corr_result_t               want;
  int                         error_count   = 0;
  int                         cycle_count   = 0;
  bit                         quiet         = 1'b0;
  bit                         long_hold_req = 1'b0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic clear_sequences();
    for (int i = 0; i < MAX_PAIRS; i++) begin
      seq_a[i] = '0;
      seq_b[i] = '0;
    end
    pair_count = 0;
    drop_seen  = 1'b0;
  endtask

  task automatic load_and_correlate(input logic signed [SAMPLE_W-1:0] a,
                                    input logic signed [SAMPLE_W-1:0] b,
                                    input logic fin);
    int           n;
    int           half;
    int           shift;
    longint       acc;
    corr_result_t r;
    if (pair_count < MAX_PAIRS) begin
      seq_a[pair_count] = a;
      seq_b[pair_count] = b;
      pair_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!fin) return;
    n = 1;
    while ((n < pair_count || n < MIN_PAIRS) && n < MAX_PAIRS) n = n * 2;
    if (n > MAX_PAIRS) n = MAX_PAIRS;
    half = n / 2;
    for (int m = 0; m < n; m++) begin
      shift = (m + n - half) % n;
      acc = 0;
      for (int j = 0; j < n; j++)
        acc += longint'(seq_a[(j + shift) % n]) * longint'(seq_b[j]);
      r.lag     = LAG_W'(m - half);
      r.corr    = CORR_W'(acc);
      r.run_end = (m == n - 1);
      r.ovf     = drop_seen;
      pending.push_back(r);
    end
    clear_sequences();
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b,
                           input logic fin);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.sample_a   <= a;
    sample_ch.sample_b   <= b;
    sample_ch.final_pair <= fin;
    forever begin
      @(posedge clk);
      if (sample_ch.ready) break;
    end
    load_and_correlate(a, b, fin);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b0);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    for (int i = 0; i < 9; i++)
      send_pair((i % 2) ? 16'sh8000 : 16'sh7FFF, (i % 3) ? 16'sh8000 : 16'sh0001, i == 8);
    for (int i = 0; i < 8; i++)
      send_pair(16'sh8000, (i == 0) ? 16'sh8000 : 16'sh0000, i == 7);
    wait_drained();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < MAX_PAIRS + 2; i++)
      send_pair(pick_sample(), pick_sample(), i == MAX_PAIRS + 1);
    wait_drained();
  endtask

  task automatic test_output_stall();
    long_hold_req = 1'b1;
    for (int r = 0; r < 3; r++)
      for (int i = 0; i < 6; i++)
        send_pair(pick_sample(), pick_sample(), i == 5);
    wait_drained();
  endtask

  task automatic test_random_runs(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        send_pair(pick_sample(), pick_sample(), i == len - 1);
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending.size() == 0) begin
        report($sformatf("result lag %0d with nothing expected", result_ch.lag));
      end else begin
        want = pending.pop_front();
        if (result_ch.lag !== want.lag)
          report($sformatf("lag got %0d want %0d", result_ch.lag, want.lag));
        if (result_ch.correlation !== want.corr)
          report($sformatf("correlation at lag %0d got %0d want %0d",
                           want.lag, result_ch.correlation, want.corr));
        if (result_ch.run_end !== want.run_end)
          report($sformatf("run_end at lag %0d got %b want %b",
                           want.lag, result_ch.run_end, want.run_end));
        if (result_ch.overflowed !== want.ovf)
          report($sformatf("overflowed at lag %0d got %b want %b",
                           want.lag, result_ch.overflowed, want.ovf));
      end
    end
  end

  initial begin
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        result_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 11) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    sample_ch.valid      = 1'b0;
    sample_ch.sample_a   = '0;
    sample_ch.sample_b   = '0;
    sample_ch.final_pair = 1'b0;
    clear_sequences();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_store_full();
    test_output_stall();
    test_random_runs(40);
    quiet = 1'b1;
    test_random_runs(15);
    wait_drained();
    if (pending.size() != 0)
      report($sformatf("%0d results never arrived", pending.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
